// File: rtl/ppks_pkg.sv
// Package for the pivot pruned k-nearest selector.
// Holds field widths, the sequencer state type and the control struct.
// No dependencies.
`timescale 1ns / 1ps

package ppks_pkg;

  localparam int ID_W        = 20;
  localparam int DIST_W      = 14;
  localparam int LB_W        = 14;
  localparam int K_W         = 5;
  localparam int SLOT_W      = 4;
  localparam int MAX_RESULTS = 16;
  localparam logic [K_W-1:0] K_RESET = 5'd16;

  typedef logic [ID_W-1:0]          id_t;
  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic [LB_W-1:0]          lb_t;
  typedef logic [K_W-1:0]           k_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic scan_en;
    logic scan_first;
    logic emit_en;
    logic emit_last;
    logic clear;
  } ctrl_t;

endpackage

// File: rtl/ppks_slot_store.sv
// Slot registers: id, distance and full flag per slot.
// One write port, one read port selected by the sequencer index.
// Depends on ppks_pkg.
`timescale 1ns / 1ps

module ppks_slot_store #(
  parameter int SLOTS = 16,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  ppks_pkg::id_t        wr_id,
  input  ppks_pkg::dist_t      wr_dist,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic                 rd_full,
  output ppks_pkg::id_t        rd_id,
  output ppks_pkg::dist_t      rd_dist
);

  ppks_pkg::id_t   id_r   [SLOTS];
  ppks_pkg::dist_t dist_r [SLOTS];
  logic [SLOTS-1:0] full_r;
  logic [SLOTS-1:0] full_nxt;

  always_comb begin
    full_nxt = full_r;
    if (clear) begin
      full_nxt = '0;
    end else if (wr_en) begin
      full_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clear) begin
      id_r[wr_idx]   <= wr_id;
      dist_r[wr_idx] <= wr_dist;
    end
  end

  assign rd_full = full_r[rd_idx];
  assign rd_id   = id_r[rd_idx];
  assign rd_dist = dist_r[rd_idx];

endmodule

// File: rtl/ppks_worst_unit.sv
// Worst-slot tracker: one signed compare stepped over the slots.
// Also decides whether an offered candidate beats the current worst.
// Depends on ppks_pkg.
`timescale 1ns / 1ps

module ppks_worst_unit #(
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ppks_pkg::ctrl_t   ctrl,
  input  logic              clear,
  input  logic [IDX_W-1:0]  idx,
  input  logic              rd_full,
  input  ppks_pkg::dist_t   rd_dist,
  input  ppks_pkg::lb_t     cand_lb,
  input  ppks_pkg::dist_t   cand_dist,
  output logic              replace,
  output logic [IDX_W-1:0]  worst_slot,
  output logic              worst_inf
);

  logic [IDX_W-1:0] worst_slot_r, worst_slot_nxt;
  ppks_pkg::dist_t  worst_dist_r, worst_dist_nxt;
  logic             worst_inf_r,  worst_inf_nxt;
  logic signed [ppks_pkg::DIST_W:0] lb_ext;
  logic signed [ppks_pkg::DIST_W:0] wd_ext;

  assign lb_ext  = $signed({1'b0, cand_lb});
  assign wd_ext  = $signed({worst_dist_r[ppks_pkg::DIST_W-1], worst_dist_r});
  assign replace = worst_inf_r || ((lb_ext < wd_ext) && (cand_dist < worst_dist_r));

  always_comb begin
    worst_slot_nxt = worst_slot_r;
    worst_dist_nxt = worst_dist_r;
    worst_inf_nxt  = worst_inf_r;
    if (clear) begin
      worst_slot_nxt = '0;
      worst_dist_nxt = '0;
      worst_inf_nxt  = 1'b1;
    end else if (ctrl.scan_en) begin
      if (ctrl.scan_first) begin
        worst_slot_nxt = idx;
        worst_inf_nxt  = !rd_full;
        worst_dist_nxt = rd_full ? rd_dist : '0;
      end else if (!rd_full) begin
        if (!worst_inf_r) begin
          worst_slot_nxt = idx;
          worst_inf_nxt  = 1'b1;
          worst_dist_nxt = '0;
        end
      end else if (!worst_inf_r && (rd_dist > worst_dist_r)) begin
        worst_slot_nxt = idx;
        worst_dist_nxt = rd_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worst_slot_r <= '0;
      worst_dist_r <= '0;
      worst_inf_r  <= 1'b1;
    end else begin
      worst_slot_r <= worst_slot_nxt;
      worst_dist_r <= worst_dist_nxt;
      worst_inf_r  <= worst_inf_nxt;
    end
  end

  assign worst_slot = worst_slot_r;
  assign worst_inf  = worst_inf_r;

endmodule

// File: rtl/ppks_seq.sv
// Sequencer: idle, worst rescan over k slots, and emit of k slots after the last candidate.
// Drives the slot index and the control struct for the other units.
// Depends on ppks_pkg.
`timescale 1ns / 1ps

module ppks_seq #(
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              replace,
  input  logic              last_cand,
  input  ppks_pkg::k_t      eff_k,
  output logic              busy,
  output logic [IDX_W-1:0]  idx,
  output ppks_pkg::ctrl_t   ctrl
);

  ppks_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             at_end;

  assign at_end = (ppks_pkg::K_W'(cnt_r) == (eff_k - ppks_pkg::K_W'(1)));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    case (state_r)
      ppks_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          last_nxt = last_cand;
          if (replace) begin
            state_nxt = ppks_pkg::ST_SCAN;
          end else if (last_cand) begin
            state_nxt = ppks_pkg::ST_EMIT;
          end
        end
      end
      ppks_pkg::ST_SCAN: begin
        if (at_end) begin
          cnt_nxt   = '0;
          state_nxt = last_r ? ppks_pkg::ST_EMIT : ppks_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ppks_pkg::ST_EMIT: begin
        if (at_end) begin
          cnt_nxt   = '0;
          last_nxt  = 1'b0;
          state_nxt = ppks_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = ppks_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = (state_r != ppks_pkg::ST_IDLE);
    idx             = cnt_r;
    ctrl.scan_en    = (state_r == ppks_pkg::ST_SCAN);
    ctrl.scan_first = (cnt_r == '0);
    ctrl.emit_en    = (state_r == ppks_pkg::ST_EMIT);
    ctrl.emit_last  = (state_r == ppks_pkg::ST_EMIT) && at_end;
    ctrl.clear      = (state_r == ppks_pkg::ST_EMIT) && at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppks_pkg::ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// File: rtl/pivot_pruned_knn_selector.sv
// Top level of the pivot pruned k-nearest selector; uses ppks_pkg, seq, worst and store units.
// A dropped candidate that is not the last leaves the block idle; one that replaces the worst
// is followed by the worst rescan through the single compare over k slots, one slot per cycle.
// A last candidate is followed by an emit of k slots; results strobe from the cycle after
// emit starts, one per cycle, and cannot be stalled. No candidate is taken in rescan or emit.
// Synchronous active-low reset empties all slots and sets k to 16.
`timescale 1ns / 1ps

module pivot_pruned_knn_selector #(
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [19:0]                   in_candidate_id,
  input  logic [13:0]                   in_lower_bound,
  input  logic signed [13:0]            in_approx_distance,
  input  logic                          in_last_candidate,
  output logic                          out_valid,
  output logic [3:0]                    out_slot_index,
  output logic                          out_neighbor_valid,
  output logic [19:0]                   out_neighbor_id,
  output logic signed [13:0]            out_neighbor_distance,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [4:0]                    cfg_data
);

  localparam int SLOTS = (MAX_NEIGHBORS < ppks_pkg::MAX_RESULTS) ?
                         MAX_NEIGHBORS : ppks_pkg::MAX_RESULTS;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ppks_pkg::k_t     k_r, k_nxt;
  ppks_pkg::k_t     eff_k;
  ppks_pkg::ctrl_t  ctrl;
  logic             accept;
  logic             cfg_fire;
  logic             clear_all;
  logic             replace;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] worst_slot;
  logic [IDX_W-1:0] wr_idx;
  logic             worst_inf;
  logic             rd_full;
  ppks_pkg::id_t    rd_id;
  ppks_pkg::dist_t  rd_dist;

  logic             out_valid_r;
  logic [3:0]       out_slot_index_r;
  logic             out_neighbor_valid_r;
  ppks_pkg::id_t    out_neighbor_id_r;
  ppks_pkg::dist_t  out_neighbor_distance_r;
  logic             out_last_r;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign clear_all = ctrl.clear || cfg_fire;

  always_comb begin
    if (k_r == '0) begin
      eff_k = ppks_pkg::K_W'(1);
    end else if (k_r > ppks_pkg::K_W'(SLOTS)) begin
      eff_k = ppks_pkg::K_W'(SLOTS);
    end else begin
      eff_k = k_r;
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (cfg_fire) begin
      k_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= ppks_pkg::K_RESET;
    end else begin
      k_r <= k_nxt;
    end
  end

  // guard a stale worst index against the current k
  assign wr_idx = (ppks_pkg::K_W'(worst_slot) >= eff_k) ? '0 : worst_slot;

  ppks_seq #(
    .IDX_W (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .replace   (replace),
    .last_cand (in_last_candidate),
    .eff_k     (eff_k),
    .busy      (busy),
    .idx       (idx),
    .ctrl      (ctrl)
  );

  ppks_worst_unit #(
    .IDX_W (IDX_W)
  ) u_worst (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .clear      (clear_all),
    .idx        (idx),
    .rd_full    (rd_full),
    .rd_dist    (rd_dist),
    .cand_lb    (in_lower_bound),
    .cand_dist  (in_approx_distance),
    .replace    (replace),
    .worst_slot (worst_slot),
    .worst_inf  (worst_inf)
  );

  ppks_slot_store #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear_all),
    .wr_en   (accept && replace),
    .wr_idx  (wr_idx),
    .wr_id   (in_candidate_id),
    .wr_dist (in_approx_distance),
    .rd_idx  (idx),
    .rd_full (rd_full),
    .rd_id   (rd_id),
    .rd_dist (rd_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_en) begin
      out_slot_index_r        <= 4'(idx);
      out_neighbor_valid_r    <= rd_full;
      out_neighbor_id_r       <= rd_full ? rd_id : '0;
      out_neighbor_distance_r <= rd_full ? rd_dist : '0;
      out_last_r              <= ctrl.emit_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_slot_index        = out_slot_index_r;
  assign out_neighbor_valid    = out_neighbor_valid_r;
  assign out_neighbor_id       = out_neighbor_id_r;
  assign out_neighbor_distance = out_neighbor_distance_r;
  assign out_last              = out_last_r;

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an emit cycle");

  a_drop_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !replace && !in_last_candidate) |=> !busy)
    else $error("dropped candidate left the block busy");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> (!out_valid && worst_inf))
    else $error("result run did not end and clear after the final slot");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && !start) |=> (worst_inf && !busy))
    else $error("register write did not empty the slot list");

endmodule
